FILE: rtl/ese_pkg.sv
// shared constants, widths and types of the encoder speed estimator
package ese_pkg;

    localparam int WINDOW_LEN     = 16;
    localparam int LOG_W          = $clog2(WINDOW_LEN);
    localparam int POS_W          = LOG_W;

    localparam int ANGLE_W        = 12;
    localparam int TS_W           = 32;
    localparam int STEP_W         = 13;
    localparam int INTERVAL_W     = 15;
    localparam int SPEED_W        = 16;
    localparam int TURNS_W        = 16;

    localparam int STEP_SUM_W     = STEP_W + LOG_W;
    localparam int INTERVAL_SUM_W = INTERVAL_W + LOG_W;
    localparam int SCALE_W        = 10;
    localparam int PROD_W         = STEP_SUM_W + SCALE_W;
    localparam int MAG_W          = PROD_W - 1;
    localparam int CNT_W          = $clog2(MAG_W + 1);

    localparam logic [ANGLE_W-1:0]    QUARTER_LOW  = ANGLE_W'(1024);
    localparam logic [ANGLE_W-1:0]    QUARTER_HIGH = ANGLE_W'(3072);
    localparam logic [STEP_W-1:0]     REVOLUTION   = STEP_W'(4096);
    localparam logic [PROD_W-1:0]     SPEED_SCALE  = PROD_W'(1000);
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = '1;

    typedef struct packed {
        logic signed [STEP_W-1:0] step;
        logic [INTERVAL_W-1:0]    interval;
    } ring_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_MUL,
        ST_ABS,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/ese_sample_if.sv
// input channel: one encoder sample per beat
interface ese_sample_if;
    logic                            valid;
    logic                            ready;
    logic [ese_pkg::ANGLE_W-1:0]     angle;
    logic [ese_pkg::TS_W-1:0]        timestamp;

    modport source (output valid, output angle, output timestamp, input ready);
    modport sink (input valid, input angle, input timestamp, output ready);
endinterface

FILE: rtl/ese_result_if.sv
// output channel: one speed result per beat
interface ese_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ese_pkg::SPEED_W-1:0]     speed;
    logic [ese_pkg::TURNS_W-1:0]            turns;
    logic signed [ese_pkg::STEP_W-1:0]      step;
    logic [ese_pkg::INTERVAL_W-1:0]         interval;

    modport source (output valid, output speed, output turns, output step,
                    output interval, input ready);
    modport sink (input valid, input speed, input turns, input step,
                  input interval, output ready);
endinterface

FILE: rtl/encoder_speed_estimator.sv
// encoder speed estimator top level: step, turns, interval, windowed speed
//
//  channel  | dir | fields
//  ---------+-----+------------------------------------------
//  sample   | in  | angle[11:0], timestamp[31:0]
//  result   | out | speed[15:0] s, turns[15:0], step[12:0] s, interval[14:0]
//
// one sample at a time; the bit-serial restoring divider gives one quotient
// bit per cycle; reset clears control, encoder and window state, not the ring
// or datapath registers; the ring needs no clearing pass, entries not yet
// written read as zero until the write pointer wraps for the first time
// a finished result sits in the output register; the next sample is taken
// while it waits, and a new result waits in its last state until it is free
module encoder_speed_estimator (
    input  logic                 clk,
    input  logic                 rst_n,
    ese_sample_if.sink           sample,
    ese_result_if.source         result
);

    ese_pkg::state_t state_reg, state_next;

    logic [ese_pkg::ANGLE_W-1:0]             prev_angle_reg;
    logic [ese_pkg::TS_W-1:0]                prev_ts_reg;
    logic [ese_pkg::TURNS_W-1:0]             turns_reg;
    logic [ese_pkg::POS_W-1:0]               pos_reg;
    logic                                    filled_reg;
    logic signed [ese_pkg::STEP_SUM_W-1:0]   step_sum_reg;
    logic [ese_pkg::INTERVAL_SUM_W-1:0]      interval_sum_reg;

    logic signed [ese_pkg::STEP_W-1:0]       step_reg;
    logic [ese_pkg::INTERVAL_W-1:0]          interval_reg;
    logic signed [ese_pkg::PROD_W-1:0]       prod_reg;
    logic                                    neg_reg;
    logic                                    zero_reg;
    logic [ese_pkg::INTERVAL_SUM_W-1:0]      rem_reg;
    logic [ese_pkg::MAG_W-1:0]               dvd_reg;
    logic [ese_pkg::CNT_W-1:0]               cnt_reg;

    logic                                    out_valid_reg;
    logic signed [ese_pkg::SPEED_W-1:0]      speed_reg;
    logic [ese_pkg::TURNS_W-1:0]             out_turns_reg;
    logic signed [ese_pkg::STEP_W-1:0]       out_step_reg;
    logic [ese_pkg::INTERVAL_W-1:0]          out_interval_reg;

    ese_pkg::ring_entry_t ring_mem [ese_pkg::WINDOW_LEN];
    ese_pkg::ring_entry_t rd_data_reg;
    ese_pkg::ring_entry_t old_entry;

    logic                                    accept;
    logic                                    load_out;

    // sample-side arithmetic
    logic                                    fwd_wrap;
    logic                                    bwd_wrap;
    logic [ese_pkg::STEP_W-1:0]              diff;
    logic [ese_pkg::STEP_W-1:0]              step_now;
    logic [ese_pkg::TS_W-1:0]                gap_full;
    logic [ese_pkg::INTERVAL_W-1:0]          gap;

    // window and divider arithmetic
    logic signed [ese_pkg::STEP_SUM_W-1:0]   step_sum_next;
    logic [ese_pkg::INTERVAL_SUM_W-1:0]      interval_sum_next;
    logic [ese_pkg::PROD_W-1:0]              prod_abs;
    logic [ese_pkg::INTERVAL_SUM_W:0]        rem_shift;
    logic [ese_pkg::INTERVAL_SUM_W:0]        rem_sub;
    logic                                    rem_ge;
    logic [ese_pkg::SPEED_W-1:0]             quot_low;
    logic [ese_pkg::SPEED_W-1:0]             speed_val;

    assign accept = sample.valid && sample.ready;

    always_comb
    begin
        fwd_wrap = (sample.angle < ese_pkg::QUARTER_LOW) &&
                   (prev_angle_reg > ese_pkg::QUARTER_HIGH);
        bwd_wrap = (sample.angle > ese_pkg::QUARTER_HIGH) &&
                   (prev_angle_reg < ese_pkg::QUARTER_LOW);
        diff = {1'b0, sample.angle} - {1'b0, prev_angle_reg};
        // plus or minus a revolution is the same top-bit flip in 13 bits
        step_now = diff;
        if (fwd_wrap)
        begin
            step_now = diff + ese_pkg::REVOLUTION;
        end
        else if (bwd_wrap)
        begin
            step_now = diff - ese_pkg::REVOLUTION;
        end
        gap_full = sample.timestamp - prev_ts_reg;
        gap = (|gap_full[ese_pkg::TS_W-1:ese_pkg::INTERVAL_W]) ?
              ese_pkg::INTERVAL_MAX : gap_full[ese_pkg::INTERVAL_W-1:0];
    end

    always_comb
    begin
        old_entry = filled_reg ? rd_data_reg : '0;
        step_sum_next = step_sum_reg
                      + ese_pkg::STEP_SUM_W'(step_reg)
                      - ese_pkg::STEP_SUM_W'(old_entry.step);
        interval_sum_next = interval_sum_reg
                          + ese_pkg::INTERVAL_SUM_W'(interval_reg)
                          - ese_pkg::INTERVAL_SUM_W'(old_entry.interval);
        prod_abs = prod_reg[ese_pkg::PROD_W-1] ? -prod_reg : prod_reg;
        rem_shift = {rem_reg, dvd_reg[ese_pkg::MAG_W-1]};
        rem_sub = rem_shift - {1'b0, interval_sum_reg};
        rem_ge = (rem_shift >= {1'b0, interval_sum_reg});
        quot_low = dvd_reg[ese_pkg::SPEED_W-1:0];
        if (zero_reg)
        begin
            speed_val = '0;
        end
        else if (neg_reg)
        begin
            speed_val = -quot_low;
        end
        else
        begin
            speed_val = quot_low;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ese_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        sample.ready = 1'b0;
        load_out     = 1'b0;
        case (state_reg)
            ese_pkg::ST_IDLE:
            begin
                sample.ready = 1'b1;
                if (sample.valid)
                begin
                    state_next = ese_pkg::ST_READ;
                end
            end
            ese_pkg::ST_READ:
            begin
                state_next = ese_pkg::ST_SUM;
            end
            ese_pkg::ST_SUM:
            begin
                state_next = ese_pkg::ST_MUL;
            end
            ese_pkg::ST_MUL:
            begin
                state_next = ese_pkg::ST_ABS;
            end
            ese_pkg::ST_ABS:
            begin
                state_next = ese_pkg::ST_DIV;
            end
            ese_pkg::ST_DIV:
            begin
                if (cnt_reg == ese_pkg::CNT_W'(1))
                begin
                    state_next = ese_pkg::ST_DONE;
                end
            end
            ese_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ese_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ese_pkg::ST_IDLE;
            end
        endcase
    end

    // encoder and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_angle_reg   <= '0;
            prev_ts_reg      <= '0;
            turns_reg        <= '0;
            pos_reg          <= '0;
            filled_reg       <= 1'b0;
            step_sum_reg     <= '0;
            interval_sum_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                prev_angle_reg <= sample.angle;
                prev_ts_reg    <= sample.timestamp;
                if (fwd_wrap)
                begin
                    turns_reg <= turns_reg + ese_pkg::TURNS_W'(1);
                end
                else if (bwd_wrap)
                begin
                    turns_reg <= turns_reg - ese_pkg::TURNS_W'(1);
                end
            end
            if (state_reg == ese_pkg::ST_SUM)
            begin
                step_sum_reg     <= step_sum_next;
                interval_sum_reg <= interval_sum_next;
                if (pos_reg == ese_pkg::POS_W'(ese_pkg::WINDOW_LEN - 1))
                begin
                    pos_reg    <= '0;
                    filled_reg <= 1'b1;
                end
                else
                begin
                    pos_reg <= pos_reg + ese_pkg::POS_W'(1);
                end
            end
        end
    end

    // ring memory, one read and one write per beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= ring_mem[pos_reg];
        end
        if (state_reg == ese_pkg::ST_SUM)
        begin
            ring_mem[pos_reg] <= '{step: step_reg, interval: interval_reg};
        end
    end

    // per-beat datapath and bit-serial divider
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            step_reg     <= $signed(step_now);
            interval_reg <= gap;
        end
        if (state_reg == ese_pkg::ST_MUL)
        begin
            prod_reg <= $signed(ese_pkg::PROD_W'(step_sum_reg))
                      * $signed(ese_pkg::SPEED_SCALE);
        end
        if (state_reg == ese_pkg::ST_ABS)
        begin
            neg_reg  <= prod_reg[ese_pkg::PROD_W-1];
            zero_reg <= (interval_sum_reg == '0);
            dvd_reg  <= prod_abs[ese_pkg::MAG_W-1:0];
            rem_reg  <= '0;
            cnt_reg  <= ese_pkg::CNT_W'(ese_pkg::MAG_W);
        end
        if (state_reg == ese_pkg::ST_DIV)
        begin
            rem_reg <= rem_ge ? rem_sub[ese_pkg::INTERVAL_SUM_W-1:0]
                              : rem_shift[ese_pkg::INTERVAL_SUM_W-1:0];
            dvd_reg <= {dvd_reg[ese_pkg::MAG_W-2:0], rem_ge};
            cnt_reg <= cnt_reg - ese_pkg::CNT_W'(1);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            speed_reg        <= $signed(speed_val);
            out_turns_reg    <= turns_reg;
            out_step_reg     <= step_reg;
            out_interval_reg <= interval_reg;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.speed    = speed_reg;
    assign result.turns    = out_turns_reg;
    assign result.step     = out_step_reg;
    assign result.interval = out_interval_reg;

`ifndef SYNTH
    // divider remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ese_pkg::ST_DIV && interval_sum_reg != '0)
            |-> (rem_reg < interval_sum_reg))
        else $error("divider remainder not below divisor");

    // once the ring is full it stays full
    assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(filled_reg))
        else $error("ring fill flag dropped");

    // a loaded result shows up as a valid beat
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> result.valid)
        else $error("loaded result not presented");

    // no sample taken while a result is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ese_pkg::ST_READ && !sample.ready))
        else $error("sample accepted outside idle");
`endif

endmodule
